[hw/rtl/bmpd_pkg.sv]
// ---------------------------------------------------------------------------
// bmpd_pkg
// Shared types and constants of the 24-bit BMP stream decoder.
// ---------------------------------------------------------------------------
package bmpd_pkg;

    typedef enum logic [2:0] {
        PH_HDR  = 3'd0,
        PH_SKIP = 3'd1,
        PH_PIX  = 3'd2,
        PH_DONE = 3'd3,
        PH_ERR  = 3'd4,
        PH_BIG  = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ST_WORK = 2'd0,
        ST_OK   = 2'd1,
        ST_FMT  = 2'd2,
        ST_BIG  = 2'd3
    } t_status;

    // which byte of a BGR triple comes next
    localparam logic [1:0] BIP_BLUE  = 2'd0;
    localparam logic [1:0] BIP_GREEN = 2'd1;
    localparam logic [1:0] BIP_RED   = 2'd2;

    // byte positions of the last byte of each checked header field
    localparam logic [31:0] POS_SIG_B      = 32'd0;
    localparam logic [31:0] POS_SIG_M      = 32'd1;
    localparam logic [31:0] POS_OFFSET_END = 32'd13;
    localparam logic [31:0] POS_HSIZE_END  = 32'd17;
    localparam logic [31:0] POS_WIDTH_END  = 32'd21;
    localparam logic [31:0] POS_HEIGHT_END = 32'd25;
    localparam logic [31:0] POS_BPP_END    = 32'd29;
    localparam logic [31:0] POS_COMPR_END  = 32'd33;
    localparam logic [31:0] POS_HDR_LAST   = 32'd53;
    localparam logic [31:0] HDR_LEN        = 32'd54;

    localparam logic [7:0]  SIG_B         = 8'h42;
    localparam logic [7:0]  SIG_M         = 8'h4D;
    localparam logic [31:0] MIN_INFO_SIZE = 32'd40;
    localparam logic [15:0] BPP_24        = 16'd24;

    typedef struct packed {
        logic        emit;
        logic        pixel_valid;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] row;
        logic [11:0] column;
        logic [12:0] width;
        logic [12:0] height;
        t_status     status;
    } t_result;

endpackage

[hw/rtl/bmpd_core.sv]
// ---------------------------------------------------------------------------
// bmpd_core
// Header parser, offset skipper and pixel unpacker; one byte per step.
// ---------------------------------------------------------------------------
module bmpd_core #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_end,
    output bmpd_pkg::t_result o_res
);
    import bmpd_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RX = (HW > 12) ? HW : 12;
    localparam int CX = (WW > 12) ? WW : 12;
    localparam int WX = (WW > 13) ? WW : 13;
    localparam int HX = (HW > 13) ? HW : 13;
    localparam logic [31:0] MAX_W32 = 32'(MAX_WIDTH);
    localparam logic [31:0] MAX_H32 = 32'(MAX_HEIGHT);

    t_phase          r_phase, n_phase;
    logic [31:0]     r_pos, n_pos;
    logic [31:0]     r_acc, n_acc;
    logic [31:0]     r_offset, n_offset;
    logic [WW-1:0]   r_width, n_width;
    logic [HW-1:0]   r_height, n_height;
    logic            r_bottom_up, n_bottom_up;
    logic            r_big, n_big;
    logic [HW-1:0]   r_row, n_row;
    logic [WW-1:0]   r_col, n_col;
    logic [1:0]      r_bip, n_bip;
    logic [1:0]      r_pad, n_pad;
    logic [7:0]      r_blue, n_blue;
    logic [7:0]      r_green, n_green;

    logic [31:0]     acc_n, pos_n, mag;
    logic [WW-1:0]   col_n;
    logic [HW-1:0]   row_n;
    logic            fail_fmt, fail_big, hdr_done, skip_done, row_end, last_row, have_pix;
    logic [RX-1:0]   row_ext;
    logic [CX-1:0]   col_ext;
    logic [WX-1:0]   width_ext;
    logic [HX-1:0]   height_ext;

    assign acc_n = {i_byte, r_acc[31:8]};
    assign pos_n = r_pos + 32'd1;
    assign mag   = acc_n[31] ? (32'd0 - acc_n) : acc_n;
    assign col_n = r_col + WW'(1);
    assign row_n = r_row + HW'(1);

    always_comb begin
        n_pos       = r_pos;
        n_acc       = r_acc;
        n_offset    = r_offset;
        n_width     = r_width;
        n_height    = r_height;
        n_bottom_up = r_bottom_up;
        n_big       = r_big;
        n_row       = r_row;
        n_col       = r_col;
        n_bip       = r_bip;
        n_pad       = r_pad;
        n_blue      = r_blue;
        n_green     = r_green;
        fail_fmt    = 1'b0;
        fail_big    = 1'b0;
        hdr_done    = 1'b0;
        skip_done   = 1'b0;
        row_end     = 1'b0;
        last_row    = 1'b0;
        have_pix    = 1'b0;
        if (i_step && (r_phase inside {PH_HDR, PH_SKIP, PH_PIX})) begin
            if (i_end) begin
                fail_fmt = 1'b1;
            end else begin
                case (r_phase)
                    PH_HDR: begin
                        n_acc = acc_n;
                        n_pos = pos_n;
                        case (r_pos)
                            POS_SIG_B: fail_fmt = (i_byte != SIG_B);
                            POS_SIG_M: fail_fmt = (i_byte != SIG_M);
                            POS_OFFSET_END: n_offset = acc_n;
                            POS_HSIZE_END: fail_fmt = (acc_n < MIN_INFO_SIZE);
                            POS_WIDTH_END: begin
                                if (acc_n[31] || acc_n == 32'd0) begin
                                    fail_fmt = 1'b1;
                                end else if (acc_n > MAX_W32) begin
                                    n_big = 1'b1;
                                end else begin
                                    n_width = acc_n[WW-1:0];
                                end
                            end
                            POS_HEIGHT_END: begin
                                if (acc_n == 32'd0) begin
                                    fail_fmt = 1'b1;
                                end else begin
                                    // negative height means rows stored top-down
                                    n_bottom_up = !acc_n[31];
                                    if (mag > MAX_H32) begin
                                        n_big = 1'b1;
                                    end else begin
                                        n_height = mag[HW-1:0];
                                    end
                                end
                            end
                            POS_BPP_END: fail_fmt = (acc_n[31:16] != BPP_24);
                            POS_COMPR_END: fail_fmt = (acc_n != 32'd0);
                            POS_HDR_LAST: begin
                                if (r_offset < HDR_LEN) begin
                                    fail_fmt = 1'b1;
                                end else if (r_big) begin
                                    fail_big = 1'b1;
                                end else begin
                                    hdr_done = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                    PH_SKIP: begin
                        n_pos     = pos_n;
                        skip_done = (pos_n == r_offset);
                    end
                    PH_PIX: begin
                        if (r_pad != 2'd0) begin
                            n_pad   = r_pad - 2'd1;
                            row_end = (r_pad == 2'd1);
                        end else begin
                            case (r_bip)
                                BIP_BLUE: begin
                                    n_blue = i_byte;
                                    n_bip  = BIP_GREEN;
                                end
                                BIP_GREEN: begin
                                    n_green = i_byte;
                                    n_bip   = BIP_RED;
                                end
                                default: begin
                                    n_bip    = BIP_BLUE;
                                    have_pix = 1'b1;
                                    if (col_n < r_width) begin
                                        n_col = col_n;
                                    end else begin
                                        // row padding count equals width mod 4 for 3-byte pixels
                                        n_col   = '0;
                                        n_pad   = r_width[1:0];
                                        row_end = (r_width[1:0] == 2'd0);
                                    end
                                end
                            endcase
                        end
                        if (row_end) begin
                            n_row    = row_n;
                            last_row = (row_n >= r_height);
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (fail_fmt || fail_big) begin
            n_width  = '0;
            n_height = '0;
        end
    end

    always_comb begin
        n_phase = r_phase;
        if (fail_fmt) begin
            n_phase = PH_ERR;
        end else if (fail_big) begin
            n_phase = PH_BIG;
        end else if (hdr_done) begin
            n_phase = (r_offset == HDR_LEN) ? PH_PIX : PH_SKIP;
        end else if (skip_done) begin
            n_phase = PH_PIX;
        end else if (last_row) begin
            n_phase = PH_DONE;
        end
    end

    assign row_ext    = r_bottom_up ? (RX'(r_height) - RX'(1) - RX'(r_row)) : RX'(r_row);
    assign col_ext    = CX'(r_col);
    assign width_ext  = WX'(r_width);
    assign height_ext = HX'(r_height);

    always_comb begin
        o_res.emit        = fail_fmt || fail_big || have_pix || last_row;
        o_res.pixel_valid = have_pix;
        o_res.red         = have_pix ? i_byte : 8'd0;
        o_res.green       = have_pix ? r_green : 8'd0;
        o_res.blue        = have_pix ? r_blue : 8'd0;
        o_res.row         = have_pix ? row_ext[11:0] : 12'd0;
        o_res.column      = have_pix ? col_ext[11:0] : 12'd0;
        o_res.width       = (fail_fmt || fail_big) ? 13'd0 : width_ext[12:0];
        o_res.height      = (fail_fmt || fail_big) ? 13'd0 : height_ext[12:0];
        if (fail_fmt) begin
            o_res.status = ST_FMT;
        end else if (fail_big) begin
            o_res.status = ST_BIG;
        end else if (last_row) begin
            o_res.status = ST_OK;
        end else begin
            o_res.status = ST_WORK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR;
            r_pos       <= '0;
            r_acc       <= '0;
            r_offset    <= '0;
            r_width     <= '0;
            r_height    <= '0;
            r_bottom_up <= 1'b1;
            r_big       <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_bip       <= BIP_BLUE;
            r_pad       <= '0;
            r_blue      <= '0;
            r_green     <= '0;
        end else begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_acc       <= n_acc;
            r_offset    <= n_offset;
            r_width     <= n_width;
            r_height    <= n_height;
            r_bottom_up <= n_bottom_up;
            r_big       <= n_big;
            r_row       <= n_row;
            r_col       <= n_col;
            r_bip       <= n_bip;
            r_pad       <= n_pad;
            r_blue      <= n_blue;
            r_green     <= n_green;
        end
    end

endmodule

[hw/rtl/bmp24_stream_decoder.sv]
// ---------------------------------------------------------------------------
// bmp24_stream_decoder
// Streaming decoder for uncompressed 24-bit BMP files, one file byte a word.
// ---------------------------------------------------------------------------
// Usage:
//   input channel: i_in_valid / o_in_stall carry one file byte a word
//   (i_data_byte), or an end marker (i_stream_end high, byte ignored).
//   output channel: o_out_valid / i_out_stall carry one result word: a
//   pixel with its destination row and column, or a status word when the
//   image is finished (status 1), malformed (2) or too large (3).
//   Most bytes give no result word.
//   A byte passes through the input register, then is decoded into the
//   result register. Throughput: one byte per cycle while the receiver
//   does not stall, set by the single decode step between the input and
//   result registers; the input register doubles as a one-word skid so a
//   byte is still taken while a result waits.
//   When the receiver stalls with a result pending and a byte is held in
//   the input register, o_in_stall rises until the result is taken.
//   Reset clears the parser to the start of a file; after a finish or an
//   error all further bytes are swallowed until the next reset.
// ---------------------------------------------------------------------------
module bmp24_stream_decoder #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_stream_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_pixel_valid,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [11:0] o_pixel_row,
    output logic [11:0] o_pixel_column,
    output logic [12:0] o_image_width,
    output logic [12:0] o_image_height,
    output logic [1:0]  o_status
);
    import bmpd_pkg::*;

    logic      r_in_vld;
    logic [7:0] r_in_byte;
    logic      r_in_end;
    logic      r_out_vld;
    t_result   r_out;
    t_result   core_res;
    logic      advance;
    logic      in_take;

    // decode may run unless a finished result is stuck at the output
    assign advance    = !(r_out_vld && i_out_stall);
    assign o_in_stall = r_in_vld && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    bmpd_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (r_in_vld && advance),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= r_in_vld && core_res.emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_end  <= i_stream_end;
        end
        if (advance && r_in_vld && core_res.emit) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_pixel_valid  = r_out.pixel_valid;
    assign o_red          = r_out.red;
    assign o_green        = r_out.green;
    assign o_blue         = r_out.blue;
    assign o_pixel_row    = r_out.row;
    assign o_pixel_column = r_out.column;
    assign o_image_width  = r_out.width;
    assign o_image_height = r_out.height;
    assign o_status       = r_out.status;

endmodule

[hw/rtl/bmpd_checker.sv]
// ---------------------------------------------------------------------------
// bmpd_checker
// Port-level checks of the BMP stream decoder, bound to the top level.
// ---------------------------------------------------------------------------
module bmpd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_pixel_valid,
    input logic [7:0]  o_red,
    input logic [11:0] o_pixel_row,
    input logic [12:0] o_image_width,
    input logic [12:0] o_image_height,
    input logic [1:0]  o_status
);
    import bmpd_pkg::*;

    // a held result word stays put while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_red) && $stable(o_pixel_row))
        else $error("result word changed under stall");

    // a word without a pixel is only sent to report an end status
    a_status_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_pixel_valid |-> o_status != ST_WORK && o_red == 8'd0
            && o_pixel_row == 12'd0)
        else $error("empty result word without end status");

    // error words carry no pixel and a cleared size
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FMT || o_status == ST_BIG)
            |-> !o_pixel_valid && o_image_width == 13'd0 && o_image_height == 13'd0)
        else $error("error word with pixel or size");

    // nothing follows a taken end status
    a_quiet_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_status != ST_WORK |=> !o_out_valid)
        else $error("result word after end status");

endmodule

bind bmp24_stream_decoder bmpd_checker u_bmpd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_pixel_valid  (o_pixel_valid),
    .o_red          (o_red),
    .o_pixel_row    (o_pixel_row),
    .o_image_width  (o_image_width),
    .o_image_height (o_image_height),
    .o_status       (o_status)
);

[verif/bmp24_stream_decoder_test.sv]
// ---------------------------------------------------------------------------
// bmp24_stream_decoder_test
// Feeds one BMP file per run, byte by byte, through the 24-bit BMP stream
// decoder. The run's seed picks the file shape: a small image, the start
// of a full-width single row or of a full-height single column, a stream
// cut short, or a faulty header. A byte-level decoder kept in
// step with the stream predicts every result word, and each result word
// is compared field by field. Both sides insert random idle bursts, and
// the receiver holds off for a long stretch once so the decoder backs up
// and stalls its input.
// ---------------------------------------------------------------------------
module bmp24_stream_decoder_test;
    import bmpd_pkg::*;

    localparam int MAX_W        = 4096;
    localparam int MAX_H        = 4096;
    localparam int HOLD_CYCLES  = 80;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 40;

    typedef enum int {
        HF_NONE,
        HF_SIG_B,
        HF_SIG_M,
        HF_INFO_SIZE,
        HF_WIDTH_ZERO,
        HF_WIDTH_NEG,
        HF_HEIGHT_ZERO,
        HF_BPP,
        HF_COMPRESSION,
        HF_OFFSET,
        HF_WIDE,
        HF_TALL,
        HF_WIDE_BAD_BPP,
        HF_END_IN_HDR,
        HF_END_IN_GAP
    } hdr_fault_e;

    typedef struct packed {
        logic        pixel_valid;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] row;
        logic [11:0] column;
        logic [12:0] width;
        logic [12:0] height;
        t_status     status;
    } pixel_word_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic [7:0]  data_byte  = 8'h00;
    logic        stream_end = 1'b0;
    logic        out_stall  = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_pixel_valid;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [11:0] o_pixel_row;
    logic [11:0] o_pixel_column;
    logic [12:0] o_image_width;
    logic [12:0] o_image_height;
    logic [1:0]  o_status;

    always #5 clk = ~clk;

    bmp24_stream_decoder #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (data_byte),
        .i_stream_end   (stream_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_pixel_valid  (o_pixel_valid),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_pixel_row    (o_pixel_row),
        .o_pixel_column (o_pixel_column),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height),
        .o_status       (o_status)
    );

    // decoder state as the predictor sees it
    t_phase      dec_phase     = PH_HDR;
    logic        dec_oversize  = 1'b0;
    logic [31:0] dec_pos       = '0;
    logic [31:0] dec_acc       = '0;
    logic [31:0] dec_offset    = '0;
    logic [31:0] dec_w         = '0;
    logic [31:0] dec_h         = '0;
    logic        dec_bottom_up = 1'b1;
    logic [31:0] dec_row       = '0;
    logic [31:0] dec_col       = '0;
    logic [1:0]  dec_bip       = BIP_BLUE;
    logic [1:0]  dec_pad       = 2'd0;
    logic [7:0]  dec_blue      = 8'h00;
    logic [7:0]  dec_green     = 8'h00;

    pixel_word_t expected_pixels[$];
    int          mismatches   = 0;
    int          quiet_cycles = 0;

    // file being streamed
    hdr_fault_e  fault = HF_NONE;
    int unsigned pic_w;
    int unsigned pic_h;
    int unsigned pixel_total;
    int unsigned gap_len;
    int          cut_pos  = -1;
    int          file_pos = 0;
    int unsigned pix_pos  = 0;
    logic [7:0]  hdr_bytes [0:53];
    logic [7:0]  pix_stream[$];

    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;
    bit hold_request   = 1'b0;

    task automatic push_result(input logic valid, input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b, input logic [31:0] row,
                               input logic [31:0] col, input t_status st);
        pixel_word_t w;
        w.pixel_valid = valid;
        w.red         = r;
        w.green       = g;
        w.blue        = b;
        w.row         = row[11:0];
        w.column      = col[11:0];
        w.width       = dec_w[12:0];
        w.height      = dec_h[12:0];
        w.status      = st;
        expected_pixels.push_back(w);
    endtask

    task automatic abort_decode(input t_phase ph, input t_status st);
        dec_phase = ph;
        dec_w     = '0;
        dec_h     = '0;
        push_result(1'b0, 8'h00, 8'h00, 8'h00, '0, '0, st);
    endtask

    task automatic close_row(input logic have_pixel, input logic [7:0] r,
                             input logic [31:0] row, input logic [31:0] col);
        dec_row++;
        if (dec_row >= dec_h) begin
            dec_phase = PH_DONE;
            if (have_pixel) push_result(1'b1, r, dec_green, dec_blue, row, col, ST_OK);
            else push_result(1'b0, 8'h00, 8'h00, 8'h00, '0, '0, ST_OK);
        end else if (have_pixel) begin
            push_result(1'b1, r, dec_green, dec_blue, row, col, ST_WORK);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic ended);
        logic [31:0] p;
        logic [31:0] acc;
        logic [31:0] mag;
        logic [31:0] row;
        logic [31:0] col;
        if (dec_phase == PH_DONE || dec_phase == PH_ERR || dec_phase == PH_BIG) return;
        if (ended) begin
            abort_decode(PH_ERR, ST_FMT);
            return;
        end
        if (dec_phase == PH_HDR) begin
            p       = dec_pos;
            acc     = {b, dec_acc[31:8]};
            dec_acc = acc;
            dec_pos = p + 1;
            case (p)
                POS_SIG_B: if (b != SIG_B) abort_decode(PH_ERR, ST_FMT);
                POS_SIG_M: if (b != SIG_M) abort_decode(PH_ERR, ST_FMT);
                POS_OFFSET_END: dec_offset = acc;
                POS_HSIZE_END: if (acc < MIN_INFO_SIZE) abort_decode(PH_ERR, ST_FMT);
                POS_WIDTH_END: begin
                    if (acc[31] || acc == '0) abort_decode(PH_ERR, ST_FMT);
                    else if (acc > 32'(MAX_W)) dec_oversize = 1'b1;
                    else dec_w = acc;
                end
                POS_HEIGHT_END: begin
                    if (acc == '0) begin
                        abort_decode(PH_ERR, ST_FMT);
                    end else begin
                        // negative height: rows stored top-down
                        dec_bottom_up = !acc[31];
                        mag = acc[31] ? 32'd0 - acc : acc;
                        if (mag > 32'(MAX_H)) dec_oversize = 1'b1;
                        else dec_h = mag;
                    end
                end
                POS_BPP_END: if (acc[31:16] != BPP_24) abort_decode(PH_ERR, ST_FMT);
                POS_COMPR_END: if (acc != '0) abort_decode(PH_ERR, ST_FMT);
                POS_HDR_LAST: begin
                    // a format error outranks a size that is too large
                    if (dec_offset < HDR_LEN) abort_decode(PH_ERR, ST_FMT);
                    else if (dec_oversize) abort_decode(PH_BIG, ST_BIG);
                    else dec_phase = (dec_offset == HDR_LEN) ? PH_PIX : PH_SKIP;
                end
                default: ;
            endcase
        end else if (dec_phase == PH_SKIP) begin
            dec_pos++;
            if (dec_pos == dec_offset) dec_phase = PH_PIX;
        end else if (dec_pad != 2'd0) begin
            dec_pad--;
            if (dec_pad == 2'd0) close_row(1'b0, 8'h00, '0, '0);
        end else if (dec_bip == BIP_BLUE) begin
            dec_blue = b;
            dec_bip  = BIP_GREEN;
        end else if (dec_bip == BIP_GREEN) begin
            dec_green = b;
            dec_bip   = BIP_RED;
        end else begin
            dec_bip = BIP_BLUE;
            row     = dec_bottom_up ? dec_h - 1 - dec_row : dec_row;
            col     = dec_col;
            dec_col++;
            if (dec_col < dec_w) begin
                push_result(1'b1, b, dec_green, dec_blue, row, col, ST_WORK);
            end else begin
                dec_col = '0;
                // row padding to a 4-byte multiple is width mod 4 bytes
                dec_pad = dec_w[1:0];
                if (dec_pad == 2'd0) close_row(1'b1, b, row, col);
                else push_result(1'b1, b, dec_green, dec_blue, row, col, ST_WORK);
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
    endtask

    task automatic check_result();
        pixel_word_t want;
        if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("result word with none expected, status %0d",
                                      o_status));
            return;
        end
        want = expected_pixels.pop_front();
        compare_field("pixel_valid", 32'(o_pixel_valid), 32'(want.pixel_valid));
        compare_field("red", 32'(o_red), 32'(want.red));
        compare_field("green", 32'(o_green), 32'(want.green));
        compare_field("blue", 32'(o_blue), 32'(want.blue));
        compare_field("pixel_row", 32'(o_pixel_row), 32'(want.row));
        compare_field("pixel_column", 32'(o_pixel_column), 32'(want.column));
        compare_field("image_width", 32'(o_image_width), 32'(want.width));
        compare_field("image_height", 32'(o_image_height), 32'(want.height));
        compare_field("status", 32'(o_status), 32'(want.status));
    endtask

    // everything is sampled at the falling edge, where all signals are settled
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_valid && !o_in_stall) decode_byte(data_byte, stream_end);
            if (o_out_valid && !out_stall) check_result();
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin : result_receiver
        int unsigned burst;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
                out_stall <= 1'b0;
            end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 18);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_word(input logic [7:0] value, input logic last_word);
        int unsigned gap;
        logic        taken;
        if (sender_idles && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= value;
        stream_end <= last_word;
        do begin
            @(negedge clk);
            taken = !o_in_stall;
            @(posedge clk);
        end while (!taken);
    endtask

    // the chosen cut position carries the end marker in place of its byte
    task automatic send_file_byte(input logic [7:0] value);
        if (file_pos == cut_pos) send_word(8'($urandom), 1'b1);
        else send_word(value, 1'b0);
        file_pos++;
    endtask

    task automatic send_pixels(input int unsigned count);
        for (int unsigned k = 0; k < count && pix_pos < pix_stream.size(); k++) begin
            send_file_byte(pix_stream[pix_pos]);
            pix_pos++;
        end
    endtask

    task automatic put_le32(input int at, input logic [31:0] value);
        for (int k = 0; k < 4; k++) hdr_bytes[at + k] = value[8*k +: 8];
    endtask

    task automatic test_file_header();
        int unsigned pick;
        int unsigned row_len;
        logic        neg;
        logic [31:0] info_size;
        logic [31:0] width_field;
        logic [31:0] height_field;
        logic [31:0] offset_field;
        logic [31:0] compr_field;
        logic [31:0] mag;
        logic [15:0] bpp_field;
        logic [7:0]  sig_b;
        logic [7:0]  sig_m;
        pick = $urandom_range(0, 99);
        neg  = 1'($urandom_range(0, 1));
        if (pick < 8) begin
            pic_w = MAX_W;
            pic_h = 1;
        end else if (pick < 16) begin
            pic_w = 1;
            pic_h = MAX_H;
        end else begin
            pic_w   = $urandom_range(1, 12);
            row_len = ((3 * pic_w + 3) / 4) * 4;
            pic_h   = 1 + 560 / row_len;
        end
        row_len     = ((3 * pic_w + 3) / 4) * 4;
        pixel_total = row_len * pic_h;
        if (pick >= 76) fault = hdr_fault_e'($urandom_range(int'(HF_SIG_B),
                                                            int'(HF_END_IN_GAP)));
        gap_len = (fault == HF_END_IN_GAP || $urandom_range(0, 1)) ? $urandom_range(1, 40) : 0;
        case ($urandom_range(0, 3))
            0, 1:    info_size = MIN_INFO_SIZE;
            2:       info_size = $urandom_range(41, 124);
            default: info_size = 32'hFFFF_FFFF;
        endcase
        width_field  = pic_w;
        height_field = neg ? 32'd0 - pic_h : pic_h;
        offset_field = HDR_LEN + gap_len;
        bpp_field    = BPP_24;
        compr_field  = '0;
        sig_b        = SIG_B;
        sig_m        = SIG_M;
        case (fault)
            HF_SIG_B:       sig_b = SIG_B ^ 8'($urandom_range(1, 255));
            HF_SIG_M:       sig_m = SIG_M ^ 8'($urandom_range(1, 255));
            HF_INFO_SIZE:   info_size = $urandom_range(0, 39);
            HF_WIDTH_ZERO:  width_field = '0;
            HF_WIDTH_NEG:   width_field = 32'h8000_0000 | $urandom;
            HF_HEIGHT_ZERO: height_field = '0;
            HF_BPP:         bpp_field = BPP_24 ^ 16'($urandom_range(1, 16'hFFFF));
            HF_COMPRESSION: compr_field = $urandom_range(1, 32'h7FFF_FFFF);
            HF_OFFSET:      offset_field = $urandom_range(0, 53);
            HF_WIDE: begin
                width_field = $urandom_range(0, 1) ? MAX_W + 1
                                                   : $urandom_range(MAX_W + 1, 32'h7FFF_FFFF);
            end
            HF_TALL: begin
                mag = $urandom_range(0, 1) ? MAX_H + 1 : $urandom_range(MAX_H + 1, 32'h7FFF_FFFF);
                height_field = neg ? 32'd0 - mag : mag;
            end
            HF_WIDE_BAD_BPP: begin
                width_field = MAX_W + 1;
                bpp_field   = 16'd32;
            end
            HF_END_IN_HDR:  cut_pos = $urandom_range(0, 53);
            HF_END_IN_GAP:  cut_pos = int'(HDR_LEN) + $urandom_range(0, gap_len - 1);
            default: ;
        endcase
        // stream cut short somewhere in the pixel data
        if (pick >= 16 && pick < 28)
            cut_pos = int'(HDR_LEN) + gap_len + $urandom_range(0, pixel_total - 1);
        // full-size shapes end after a few hundred pixel bytes
        if (pick < 16) begin
            cut_pos     = int'(HDR_LEN) + gap_len + $urandom_range(480, 560);
            pixel_total = cut_pos + 1 - int'(HDR_LEN) - gap_len;
        end
        for (int k = 0; k < HDR_LEN; k++) hdr_bytes[k] = 8'($urandom);
        hdr_bytes[POS_SIG_B] = sig_b;
        hdr_bytes[POS_SIG_M] = sig_m;
        put_le32(2, HDR_LEN + gap_len + pixel_total);  // file size
        put_le32(POS_OFFSET_END - 3, offset_field);
        put_le32(POS_HSIZE_END - 3, info_size);
        put_le32(POS_WIDTH_END - 3, width_field);
        put_le32(POS_HEIGHT_END - 3, height_field);
        put_le32(POS_BPP_END - 3, {bpp_field, 16'd1});
        put_le32(POS_COMPR_END - 3, compr_field);
        for (int k = 0; k < HDR_LEN; k++) send_file_byte(hdr_bytes[k]);
    endtask

    task automatic test_offset_gap();
        for (int unsigned k = 0; k < gap_len; k++) send_file_byte(8'($urandom));
    endtask

    task automatic test_pixel_extremes();
        logic [7:0] v;
        for (int unsigned k = 0; k < pixel_total; k++) begin
            // three black bytes, three white bytes, alternating and single-bit patterns, then random bytes
            case (k)
                0, 1, 2: v = 8'h00;
                3, 4, 5: v = 8'hFF;
                6:       v = 8'h55;
                7:       v = 8'hAA;
                8:       v = 8'h01;
                9:       v = 8'h80;
                10:      v = 8'h7F;
                11:      v = 8'hFE;
                default: v = 8'($urandom);
            endcase
            pix_stream.push_back(v);
        end
        send_pixels(18);
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        send_pixels(60);
    endtask

    task automatic test_random_pixels();
        int unsigned target;
        target = pixel_total * 85 / 100;
        if (target > pix_pos) send_pixels(target - pix_pos);
    endtask

    task automatic test_quiet_finish();
        int unsigned trailing;
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        send_pixels(pixel_total);
        // bytes and the end marker after the image are swallowed
        trailing = $urandom_range(0, 6);
        repeat (trailing) send_word(8'($urandom), 1'b0);
        send_word(8'($urandom), 1'b1);
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_file_header();
        test_offset_gap();
        test_pixel_extremes();
        test_backpressure();
        test_random_pixels();
        test_quiet_finish();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule
